[rtl/kdpc_pkg.sv]
// shared types, constants and tables for the kirsch directional pattern code block
`timescale 1ns / 1ps
package kdpc_pkg;

    localparam int PIX_W   = 8;
    localparam int NUM_DIR = 8;
    localparam int RESP_W  = 14;   // 8*s3 - 3*total spans -3825..3825
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 6;

    localparam logic [CNT_W-1:0] TOP_COUNT_RST = 4'd3;
    localparam logic [CNT_W-1:0] TOP_COUNT_MAX = 4'd8;

    // neighbour order in the window vector: nw n ne w e sw s se (0..7)
    typedef logic [NUM_DIR-1:0][PIX_W-1:0]         t_pix_arr;
    typedef logic signed [RESP_W-1:0]              t_resp;
    typedef logic [NUM_DIR-1:0][RESP_W-1:0]        t_resp_arr;
    typedef logic [255:0][IDX_W-1:0]               t_rank_tbl;

    // neighbours with weight 5 for each compass direction, bit i = neighbour i
    function automatic logic [NUM_DIR-1:0] f_strong_mask(input logic [2:0] dir);
        logic [NUM_DIR-1:0] m;
        case (dir)
            3'd0:    m = 8'b1001_0100;  // east: ne e se
            3'd1:    m = 8'b0001_0110;  // northeast: n ne e
            3'd2:    m = 8'b0000_0111;  // north: nw n ne
            3'd3:    m = 8'b0000_1011;  // northwest: nw n w
            3'd4:    m = 8'b0010_1001;  // west: nw w sw
            3'd5:    m = 8'b0110_1000;  // southwest: w sw s
            3'd6:    m = 8'b1110_0000;  // south: sw s se
            default: m = 8'b1101_0000;  // southeast: e s se
        endcase
        return m;
    endfunction

    // rank of every three-bit code in descending enumeration, other codes map to 0
    function automatic t_rank_tbl f_rank_tbl();
        t_rank_tbl tbl;
        int i;
        int j;
        int k;
        int p;
        tbl = '0;
        p   = 0;
        for (i = 7; i >= 2; i--) begin
            for (j = i - 1; j >= 1; j--) begin
                for (k = j - 1; k >= 0; k--) begin
                    tbl[(1 << i) | (1 << j) | (1 << k)] = IDX_W'(p);
                    p++;
                end
            end
        end
        return tbl;
    endfunction

    localparam t_rank_tbl RANK_TBL = f_rank_tbl();

endpackage

[rtl/kirsch_directional_pattern_code_top.sv]
// a window accepted on start shows its result with o_valid after the input, response and result registers
// throughput: one window per clock, the result strobe cannot be held off
// busy stays low; stages are input register, response register and result register
// synchronous active-low reset clears the stage valids and sets top_count to 3
// top_count is sampled when a window passes the ranking stage
`timescale 1ns / 1ps
module kirsch_directional_pattern_code_top
    import kdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic [PIX_W-1:0]   i_pix_nw,
    input  logic [PIX_W-1:0]   i_pix_n,
    input  logic [PIX_W-1:0]   i_pix_ne,
    input  logic [PIX_W-1:0]   i_pix_w,
    input  logic [PIX_W-1:0]   i_pix_e,
    input  logic [PIX_W-1:0]   i_pix_sw,
    input  logic [PIX_W-1:0]   i_pix_s,
    input  logic [PIX_W-1:0]   i_pix_se,
    output logic               o_valid,
    output logic [NUM_DIR-1:0] o_direction_code,
    output logic [IDX_W-1:0]   o_pattern_index
);

    logic [CNT_W-1:0]   r_top_count;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    t_pix_arr           r_pix;
    t_resp_arr          r_resp;
    t_resp_arr          n_resp;
    logic [NUM_DIR-1:0] r_code;
    logic [NUM_DIR-1:0] n_code;
    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   n_index;

    assign busy = 1'b0;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_COUNT_RST;
        end else if (i_cfg_we) begin
            r_top_count <= i_cfg_data;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // input register on each transfer
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_pix <= {i_pix_se, i_pix_s, i_pix_sw, i_pix_e,
                      i_pix_w, i_pix_ne, i_pix_n, i_pix_nw};
        end
    end

    kdpc_resp u_resp (
        .i_pix  (r_pix),
        .o_resp (n_resp)
    );

    // response register
    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    kdpc_rank u_rank (
        .i_resp      (r_resp),
        .i_top_count (r_top_count),
        .o_code      (n_code),
        .o_index     (n_index)
    );

    // result register
    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_index <= n_index;
    end

    assign o_valid          = r_v3;
    assign o_direction_code = r_code;
    assign o_pattern_index  = r_index;

`ifndef SYNTHESIS
    // every result strobe traces back to a transfer that passed through r_v1, r_v2 and r_v3
    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result strobe without a matching transfer");

    // codes without exactly three marks carry index zero
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $countones(o_direction_code) != 3) |-> (o_pattern_index == '0))
        else $error("nonzero pattern index on a non-triple code");

    // three-mark codes index into the 56 entries
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $countones(o_direction_code) == 3) |-> (o_pattern_index <= 6'd55))
        else $error("pattern index out of range");

    // no strobe in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule

[rtl/kdpc_resp.sv]
// eight kirsch compass responses of one 3x3 neighbourhood
`timescale 1ns / 1ps
module kdpc_resp
    import kdpc_pkg::*;
(
    input  t_pix_arr  i_pix,
    output t_resp_arr o_resp
);

    logic [PIX_W+2:0] total;

    // sum of all eight neighbours
    always_comb begin
        total = '0;
        for (int i = 0; i < NUM_DIR; i++) begin
            total = total + (PIX_W+3)'(i_pix[i]);
        end
    end

    // per direction: 8 * (sum of weight-5 neighbours) - 3 * total
    always_comb begin
        logic [NUM_DIR-1:0] mask;
        logic [PIX_W+1:0]   s3;
        for (int d = 0; d < NUM_DIR; d++) begin
            mask = f_strong_mask(3'(d));
            s3   = '0;
            for (int i = 0; i < NUM_DIR; i++) begin
                if (mask[i]) begin
                    s3 = s3 + (PIX_W+2)'(i_pix[i]);
                end
            end
            o_resp[d] = RESP_W'({1'b0, s3, 3'b000})
                      - RESP_W'({1'b0, total, 1'b0})
                      - RESP_W'({1'b0, total});
        end
    end

endmodule

[rtl/kdpc_rank.sv]
// ranks the responses, marks the strongest directions and looks up the pattern index
`timescale 1ns / 1ps
module kdpc_rank
    import kdpc_pkg::*;
(
    input  t_resp_arr          i_resp,
    input  logic [CNT_W-1:0]   i_top_count,
    output logic [NUM_DIR-1:0] o_code,
    output logic [IDX_W-1:0]   o_index
);

    logic [CNT_W-1:0]                 limit;
    logic [NUM_DIR-1:0][NUM_DIR-1:0]  beats;   // beats[e][d]: e ranks ahead of d
    logic [NUM_DIR-1:0][2:0]          rank;

    // counts above eight mark every direction
    assign limit = (i_top_count > TOP_COUNT_MAX) ? TOP_COUNT_MAX : i_top_count;

    // pairwise compare, ties go to the lower direction
    always_comb begin
        beats = '0;
        for (int e = 0; e < NUM_DIR; e++) begin
            for (int d = 0; d < NUM_DIR; d++) begin
                if (e < d) begin
                    beats[e][d] = ($signed(i_resp[e]) >= $signed(i_resp[d]));
                end else if (e > d) begin
                    beats[e][d] = ($signed(i_resp[e]) > $signed(i_resp[d]));
                end
            end
        end
    end

    // rank of each direction and the mark code, direction 0 in the top bit
    always_comb begin
        for (int d = 0; d < NUM_DIR; d++) begin
            rank[d] = '0;
            for (int e = 0; e < NUM_DIR; e++) begin
                rank[d] = rank[d] + 3'(beats[e][d]);
            end
            o_code[NUM_DIR-1-d] = ({1'b0, rank[d]} < limit);
        end
    end

    assign o_index = RANK_TBL[o_code];

endmodule

[verif/tb.sv]
// self-checking testbench for the kirsch directional pattern code block
`timescale 1ns / 1ps
module tb
    import kdpc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // one 3x3 neighbourhood, nw in the top byte down to se in the bottom byte
    typedef struct packed {
        logic [PIX_W-1:0] nw;
        logic [PIX_W-1:0] n;
        logic [PIX_W-1:0] ne;
        logic [PIX_W-1:0] w;
        logic [PIX_W-1:0] e;
        logic [PIX_W-1:0] sw;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] se;
    } t_window;

    typedef struct packed {
        logic [NUM_DIR-1:0] code;
        logic [IDX_W-1:0]   idx;
    } t_pattern;

    // directed stimulus row: fixed rows carry a hand-derived pattern
    typedef struct packed {
        logic [CNT_W-1:0]   tc;
        t_window            win;
        logic               fixed;
        logic [NUM_DIR-1:0] code;
        logic [IDX_W-1:0]   idx;
    } t_dir_row;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_data;
    t_window            drive_win;
    logic               o_valid;
    logic [NUM_DIR-1:0] o_direction_code;
    logic [IDX_W-1:0]   o_pattern_index;

    t_pattern           pending_codes [$];
    t_dir_row           directed_rows [$];
    logic [CNT_W-1:0]   top_count_q;
    bit                 idle_en;
    int                 mismatch_cnt = 0;
    int                 stall_cycles = 0;

    kirsch_directional_pattern_code_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_pix_nw         (drive_win.nw),
        .i_pix_n          (drive_win.n),
        .i_pix_ne         (drive_win.ne),
        .i_pix_w          (drive_win.w),
        .i_pix_e          (drive_win.e),
        .i_pix_sw         (drive_win.sw),
        .i_pix_s          (drive_win.s),
        .i_pix_se         (drive_win.se),
        .o_valid          (o_valid),
        .o_direction_code (o_direction_code),
        .o_pattern_index  (o_pattern_index)
    );

    // clock
    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // kirsch responses, descending rank with ties to the lower direction, triple rank
    function automatic t_pattern kirsch_code(input t_window win, input logic [CNT_W-1:0] tc);
        int       p [8];
        int       resp [8];
        int       tot;
        int       lim;
        int       rank;
        int       pos;
        int       d;
        int       o;
        int       i;
        int       j;
        int       k;
        t_pattern r;
        p[0] = win.nw;
        p[1] = win.n;
        p[2] = win.ne;
        p[3] = win.w;
        p[4] = win.e;
        p[5] = win.sw;
        p[6] = win.s;
        p[7] = win.se;
        tot = 0;
        for (d = 0; d < 8; d++) tot += p[d];
        // weight 5 on three neighbours, -3 on the rest: 8*strong - 3*all
        resp[0] = 8 * (p[2] + p[4] + p[7]) - 3 * tot;  // east
        resp[1] = 8 * (p[1] + p[2] + p[4]) - 3 * tot;  // northeast
        resp[2] = 8 * (p[0] + p[1] + p[2]) - 3 * tot;  // north
        resp[3] = 8 * (p[0] + p[1] + p[3]) - 3 * tot;  // northwest
        resp[4] = 8 * (p[0] + p[3] + p[5]) - 3 * tot;  // west
        resp[5] = 8 * (p[3] + p[5] + p[6]) - 3 * tot;  // southwest
        resp[6] = 8 * (p[5] + p[6] + p[7]) - 3 * tot;  // south
        resp[7] = 8 * (p[4] + p[6] + p[7]) - 3 * tot;  // southeast
        lim = (tc > 8) ? 8 : int'(tc);
        r = '0;
        for (d = 0; d < 8; d++) begin
            rank = 0;
            for (o = 0; o < 8; o++) begin
                if (resp[o] > resp[d] || (resp[o] == resp[d] && o < d)) rank++;
            end
            if (rank < lim) r.code[7-d] = 1'b1;
        end
        // descending enumeration of codes with exactly three set bits
        pos = 0;
        for (i = 7; i >= 2; i--) begin
            for (j = i - 1; j >= 1; j--) begin
                for (k = j - 1; k >= 0; k--) begin
                    if (int'(r.code) == ((1 << i) | (1 << j) | (1 << k))) r.idx = IDX_W'(pos);
                    pos++;
                end
            end
        end
        return r;
    endfunction

    // random window: free values, black/white, near-flat with ties, flat with one outlier
    function automatic t_window rand_window();
        t_window          win;
        logic [PIX_W-1:0] px [8];
        int               mode;
        int               base;
        int               d;
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 252);
        for (d = 0; d < 8; d++) begin
            case (mode)
                0:       px[d] = PIX_W'($urandom_range(0, 255));
                1:       px[d] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2:       px[d] = PIX_W'(base + $urandom_range(0, 3));
                default: px[d] = PIX_W'(base);
            endcase
        end
        if (mode == 3) px[$urandom_range(0, 7)] = PIX_W'($urandom_range(0, 255));
        win = {px[0], px[1], px[2], px[3], px[4], px[5], px[6], px[7]};
        return win;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input logic [CNT_W-1:0] tc, input t_window win,
                                    input logic fixed, input logic [NUM_DIR-1:0] code,
                                    input logic [IDX_W-1:0] idx);
        t_dir_row r;
        r.tc    = tc;
        r.win   = win;
        r.fixed = fixed;
        r.code  = code;
        r.idx   = idx;
        directed_rows = {directed_rows, r};
    endfunction

    // one window transfer, with random idle cycles ahead of it
    task automatic send_window(input t_window win, input logic fixed,
                               input logic [NUM_DIR-1:0] code, input logic [IDX_W-1:0] idx);
        t_pattern want;
        while (idle_en && $urandom_range(0, 99) < 25) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        drive_win <= win;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (fixed) begin
            want.code = code;
            want.idx  = idx;
        end else begin
            want = kirsch_code(win, top_count_q);
        end
        pending_codes = {pending_codes, want};
    endtask

    // register write once the pipeline has drained
    task automatic write_top_count(input logic [CNT_W-1:0] val);
        start <= 1'b0;
        while (pending_codes.size() != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we      <= 1'b0;
        top_count_q = val;
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk) begin : check_results
        t_pattern want;
        if (rst_n && o_valid) begin
            if (pending_codes.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("tb: unexpected result code %h index %0d at %0t",
                             o_direction_code, o_pattern_index, $realtime);
            end else begin
                want = pending_codes.pop_front();
                if (o_direction_code !== want.code || o_pattern_index !== want.idx) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("tb: mismatch at %0t: code exp %h got %h, index exp %0d got %0d",
                                 $realtime, want.code, o_direction_code, want.idx,
                                 o_pattern_index);
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int               ph;
        logic [CNT_W-1:0] tc;
        start        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        drive_win    <= '0;
        rst_n        <= 1'b0;
        top_count_q  = TOP_COUNT_RST;
        idle_en      = 1'b1;

        // flat windows tie everywhere, single bright neighbours, bit patterns, register extremes
        add_row(4'd3,  64'h00000000_00000000, 1'b1, 8'hE0, 6'd0);
        add_row(4'd3,  64'hFFFFFFFF_FFFFFFFF, 1'b1, 8'hE0, 6'd0);
        add_row(4'd3,  64'h00000000_FF000000, 1'b1, 8'hC1, 6'd5);
        add_row(4'd3,  64'hFF000000_00000000, 1'b1, 8'h38, 6'd36);
        add_row(4'd3,  64'h00000000_000000FF, 1'b1, 8'h83, 6'd20);
        add_row(4'd3,  64'h00FF0000_00000000, 1'b0, '0, '0);
        add_row(4'd3,  64'h0000FF00_00000000, 1'b0, '0, '0);
        add_row(4'd3,  64'h000000FF_00000000, 1'b0, '0, '0);
        add_row(4'd3,  64'h00000000_00FF0000, 1'b0, '0, '0);
        add_row(4'd3,  64'h00000000_0000FF00, 1'b0, '0, '0);
        add_row(4'd3,  64'h55555555_55555555, 1'b0, '0, '0);
        add_row(4'd3,  64'hAAAAAAAA_AAAAAAAA, 1'b0, '0, '0);
        add_row(4'd3,  64'h0F0F0F0F_0F0F0F0F, 1'b0, '0, '0);
        add_row(4'd3,  64'hF0F0F0F0_F0F0F0F0, 1'b0, '0, '0);
        add_row(4'd3,  64'h01020304_05060708, 1'b0, '0, '0);
        add_row(4'd0,  64'h12345678_9ABCDEF0, 1'b1, 8'h00, 6'd0);
        add_row(4'd8,  64'h12345678_9ABCDEF0, 1'b1, 8'hFF, 6'd0);
        add_row(4'd15, 64'h12345678_9ABCDEF0, 1'b1, 8'hFF, 6'd0);
        add_row(4'd1,  64'hFF000000_00000000, 1'b0, '0, '0);
        add_row(4'd2,  64'h00FF0000_000000FF, 1'b0, '0, '0);
        add_row(4'd4,  64'h00000000_FF00FF00, 1'b0, '0, '0);
        add_row(4'd7,  64'h80402010_08040201, 1'b0, '0, '0);
        add_row(4'd3,  64'hFFFFFFFF_00000000, 1'b0, '0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].tc != top_count_q) write_top_count(directed_rows[r].tc);
            send_window(directed_rows[r].win, directed_rows[r].fixed,
                        directed_rows[r].code, directed_rows[r].idx);
        end

        // random phases, one setting each; phase 3 runs back to back
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       tc = 4'd3;
                1:       tc = 4'd1;
                2:       tc = 4'd5;
                3:       tc = 4'd2;
                4:       tc = CNT_W'($urandom_range(0, 15));
                5:       tc = 4'd6;
                default: tc = 4'd4;
            endcase
            idle_en = (ph != 3);
            write_top_count(tc);
            repeat (100) send_window(rand_window(), 1'b0, '0, '0);
        end

        // drain and report
        start <= 1'b0;
        while (pending_codes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && pending_codes.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[kirsch_directional_pattern_code_top.f]
rtl/kdpc_pkg.sv
rtl/kdpc_resp.sv
rtl/kdpc_rank.sv
rtl/kirsch_directional_pattern_code_top.sv
verif/tb.sv
